@@ design/mbcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor base command drive package
// Shared codes, widths, payload structs and the bridge drive function.
// ----------------------------------------------------------------------------
package mbcd_pkg;

    localparam int WORD_W   = 16;
    localparam int DUTY_W   = 15;
    localparam int STEP_W   = 2;
    localparam int INDEX_W  = 3;

    localparam logic [DUTY_W-1:0]  PWM_MAX_RESET = 15'd999;
    localparam logic [INDEX_W-1:0] STATUS_LAST   = 3'd5;

    typedef enum logic [1:0] {
        REQ_COMMAND = 2'd0,
        REQ_STATUS  = 2'd1,
        REQ_STEP    = 2'd2
    } req_kind_t;

    typedef enum logic [7:0] {
        CMD_CLEAR_COUNTS = 8'd1,
        CMD_LOAD_A       = 8'd2,
        CMD_LOAD_B       = 8'd5,
        CMD_LOAD_C       = 8'd6
    } cmd_code_t;

    typedef enum logic [1:0] {
        DIR_STOP     = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } dir_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [7:0]               command;
        logic signed [WORD_W-1:0] left_value;
        logic signed [WORD_W-1:0] right_value;
        logic signed [STEP_W-1:0] left_step;
        logic signed [STEP_W-1:0] right_step;
    } item_t;

    typedef struct packed {
        dir_t              dir;
        logic [DUTY_W-1:0] duty;
    } drive_t;

    typedef struct packed {
        drive_t            left_drive;
        drive_t            right_drive;
        logic              is_status;
        logic [WORD_W-1:0] left_count;
        logic [WORD_W-1:0] right_count;
        logic [WORD_W-1:0] left_setpoint;
        logic [WORD_W-1:0] right_setpoint;
    } result_t;

    function automatic drive_t drive_side(input logic [WORD_W-1:0] sp,
                                          input logic [DUTY_W-1:0] pwm_max);
        drive_t            d;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] limit;
        limit = {1'b0, pwm_max};
        if (sp[WORD_W-1])
        begin
            mag   = WORD_W'(~sp + 1'b1);
            d.dir = DIR_BACKWARD;
        end
        else
        begin
            mag   = sp;
            d.dir = DIR_FORWARD;
        end
        if (mag > limit)
        begin
            mag = limit;
        end
        d.duty = mag[DUTY_W-1:0];
        if (sp == '0)
        begin
            d.dir  = DIR_STOP;
            d.duty = '0;
        end
        return d;
    endfunction

endpackage

@@ design/mbcd_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface mbcd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         command;
    logic signed [15:0] left_value;
    logic signed [15:0] right_value;
    logic signed [1:0]  left_step;
    logic signed [1:0]  right_step;

    modport source (output valid, req_type, command, left_value, right_value,
                    left_step, right_step, input ready);
    modport sink (input valid, req_type, command, left_value, right_value,
                  left_step, right_step, output ready);
endinterface

@@ design/mbcd_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one drive and status word.
// ----------------------------------------------------------------------------
interface mbcd_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         left_dir;
    logic [14:0]        left_duty;
    logic [1:0]         right_dir;
    logic [14:0]        right_duty;
    logic [2:0]         status_index;
    logic signed [15:0] status_word;
    logic               last;

    modport source (output valid, left_dir, left_duty, right_dir, right_duty,
                    status_index, status_word, last, input ready);
    modport sink (input valid, left_dir, left_duty, right_dir, right_duty,
                  status_index, status_word, last, output ready);
endinterface

@@ design/mbcd_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor base command execution
// Holds setpoints and encoder counts, applies one request word and forms
// the drive state and status snapshot for it.
// ----------------------------------------------------------------------------
module mbcd_exec
    import mbcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  item_t             item,
    input  logic [DUTY_W-1:0] pwm_max,
    output result_t           res
);

    logic [WORD_W-1:0] left_sp_reg, left_sp_next;
    logic [WORD_W-1:0] right_sp_reg, right_sp_next;
    logic [WORD_W-1:0] left_cnt_reg, left_cnt_next;
    logic [WORD_W-1:0] right_cnt_reg, right_cnt_next;
    logic [WORD_W-1:0] left_inc;
    logic [WORD_W-1:0] right_inc;

    always_comb
    begin
        left_sp_next   = left_sp_reg;
        right_sp_next  = right_sp_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        left_inc  = {{(WORD_W-STEP_W){item.left_step[STEP_W-1]}}, item.left_step};
        right_inc = {{(WORD_W-STEP_W){item.right_step[STEP_W-1]}}, item.right_step};
        case (item.req_type)
            REQ_COMMAND:
            begin
                if (item.command == CMD_CLEAR_COUNTS)
                begin
                    left_cnt_next  = '0;
                    right_cnt_next = '0;
                end
                else if (item.command == CMD_LOAD_A || item.command == CMD_LOAD_B ||
                         item.command == CMD_LOAD_C)
                begin
                    left_sp_next  = item.left_value;
                    right_sp_next = item.right_value;
                end
            end
            REQ_STEP:
            begin
                left_cnt_next  = left_cnt_reg + left_inc;
                right_cnt_next = right_cnt_reg + right_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.left_drive     = drive_side(left_sp_next, pwm_max);
        res.right_drive    = drive_side(right_sp_next, pwm_max);
        res.is_status      = (item.req_type == REQ_STATUS);
        res.left_count     = left_cnt_reg;
        res.right_count    = right_cnt_reg;
        res.left_setpoint  = left_sp_reg;
        res.right_setpoint = right_sp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sp_reg   <= '0;
            right_sp_reg  <= '0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
        end
        else if (fire)
        begin
            left_sp_reg   <= left_sp_next;
            right_sp_reg  <= right_sp_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
        end
    end

endmodule

@@ design/mbcd_burst.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor base response register
// Holds one result and plays it out as a single word or a six-word status
// burst.
// ----------------------------------------------------------------------------
module mbcd_burst
    import mbcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_t      res,
    output logic         free,
    mbcd_rsp_if.source   rsp
);

    logic                valid_reg, valid_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    result_t             res_reg;
    logic                is_last;
    logic [WORD_W-1:0]   word;

    assign is_last = !res_reg.is_status || (idx_reg == STATUS_LAST);
    assign free    = !valid_reg || (rsp.ready && is_last);

    always_comb
    begin
        case (idx_reg)
            3'd1:    word = res_reg.left_count;
            3'd2:    word = res_reg.right_count;
            3'd3:    word = res_reg.left_setpoint;
            3'd4:    word = res_reg.right_setpoint;
            default: word = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && rsp.ready)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.left_dir     = res_reg.left_drive.dir;
    assign rsp.left_duty    = res_reg.left_drive.duty;
    assign rsp.right_dir    = res_reg.right_drive.dir;
    assign rsp.right_duty   = res_reg.right_drive.duty;
    assign rsp.status_index = res_reg.is_status ? idx_reg : '0;
    assign rsp.status_word  = res_reg.is_status ? word : '0;
    assign rsp.last         = is_last;

endmodule

@@ design/motor_base_command_drive.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor base command drive
// A request word is held in the input register and then loaded into the
// response register once that register is free. Throughput: one request
// word per cycle for commands and encoder steps while the receiver takes
// every result; a status read holds the response register for its six words.
// Reset clears setpoints, counts and both valid flags and sets pwm_max to 999.
// ----------------------------------------------------------------------------
module motor_base_command_drive
    import mbcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DUTY_W-1:0] cfg_wr_data,
    mbcd_req_if.sink          req,
    mbcd_rsp_if.source        rsp
);

    logic              in_valid_reg, in_valid_next;
    item_t             item_reg;
    logic [DUTY_W-1:0] pwm_max_reg;
    logic              free;
    logic              fire;
    logic              accept;
    result_t           res;

    assign fire      = in_valid_reg && free;
    assign req.ready = !in_valid_reg || free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pwm_max_reg  <= PWM_MAX_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en)
            begin
                pwm_max_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type    <= req.req_type;
            item_reg.command     <= req.command;
            item_reg.left_value  <= req.left_value;
            item_reg.right_value <= req.right_value;
            item_reg.left_step   <= req.left_step;
            item_reg.right_step  <= req.right_step;
        end
    end

    mbcd_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .pwm_max (pwm_max_reg),
        .res     (res)
    );

    mbcd_burst u_burst (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .res   (res),
        .free  (free),
        .rsp   (rsp)
    );

    a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp.valid)
        else $error("Processed word did not reach the response register.");

    a_burst_advances: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last |=>
            rsp.valid && (rsp.status_index == 3'($past(rsp.status_index) + 3'd1)))
        else $error("Status burst did not step to the next word.");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status_index != '0 && rsp.last |->
            rsp.status_index == STATUS_LAST)
        else $error("Status burst ended early.");

    a_held_word_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("Held request word was dropped.");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor base command drive testbench
// Sends command frames, status reads and encoder steps to the block and keeps
// its own model of the setpoints, encoder counts and duty limit. Every result
// word is checked field by field against the oldest expected word. A short
// directed table comes first, followed by random phases under several duty
// limits, random idling on both channels, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import mbcd_pkg::*;

    localparam logic [1:0] REQ_UNUSED       = 2'd3;
    localparam logic [7:0] CMD_UNKNOWN_LOW  = 8'd0;
    localparam logic [7:0] CMD_UNKNOWN_MID  = 8'd3;
    localparam logic [7:0] CMD_UNKNOWN_HIGH = 8'd255;
    localparam int STATUS_WORDS    = 6;
    localparam int PHASE_ITEMS     = 22;
    localparam int HOLD_CYCLES     = 80;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        dir_t              left_dir;
        logic [DUTY_W-1:0] left_duty;
        dir_t              right_dir;
        logic [DUTY_W-1:0] right_duty;
        logic [2:0]        status_index;
        logic [WORD_W-1:0] status_word;
        logic              last;
    } bridge_report_t;

    typedef struct {
        item_t             req;
        bit                fixed;
        dir_t              left_dir;
        logic [DUTY_W-1:0] left_duty;
        dir_t              right_dir;
        logic [DUTY_W-1:0] right_duty;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [DUTY_W-1:0] cfg_wr_data;

    mbcd_req_if req_bus ();
    mbcd_rsp_if rsp_bus ();

    motor_base_command_drive u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    logic [DUTY_W-1:0] duty_limit;
    logic [WORD_W-1:0] sp_left;
    logic [WORD_W-1:0] sp_right;
    logic [WORD_W-1:0] enc_left;
    logic [WORD_W-1:0] enc_right;

    bridge_report_t expected_reports[$];
    script_row_t    script[$];
    int             fault_count = 0;
    int             stall_cycles = 0;
    int             hold_left = 0;
    bit             hold_req = 1'b0;
    bit             sender_calm = 1'b0;
    bit             sink_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void bridge_for(input logic [WORD_W-1:0] setpoint,
                                       output dir_t dir,
                                       output logic [DUTY_W-1:0] duty);
        int value;
        int mag;
        value = int'($signed(setpoint));
        mag = (value < 0) ? -value : value;
        if (mag > int'(duty_limit))
        begin
            mag = int'(duty_limit);
        end
        if (value == 0)
        begin
            dir = DIR_STOP;
        end
        else if (value > 0)
        begin
            dir = DIR_FORWARD;
        end
        else
        begin
            dir = DIR_BACKWARD;
        end
        duty = DUTY_W'(mag);
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(1100));
            5: return -16'($urandom_range(1100));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apply_request(input script_row_t row);
        logic [WORD_W-1:0] words [STATUS_WORDS];
        bridge_report_t    rep;
        int                count;
        if (row.req.req_type == REQ_COMMAND)
        begin
            if (row.req.command == CMD_CLEAR_COUNTS)
            begin
                enc_left  = '0;
                enc_right = '0;
            end
            else if (row.req.command == CMD_LOAD_A || row.req.command == CMD_LOAD_B ||
                     row.req.command == CMD_LOAD_C)
            begin
                sp_left  = row.req.left_value;
                sp_right = row.req.right_value;
            end
        end
        else if (row.req.req_type == REQ_STEP)
        begin
            enc_left  = enc_left + {{(WORD_W-STEP_W){row.req.left_step[1]}}, row.req.left_step};
            enc_right = enc_right +
                        {{(WORD_W-STEP_W){row.req.right_step[1]}}, row.req.right_step};
        end
        bridge_for(sp_left, rep.left_dir, rep.left_duty);
        bridge_for(sp_right, rep.right_dir, rep.right_duty);
        if (row.fixed)
        begin
            rep.left_dir   = row.left_dir;
            rep.left_duty  = row.left_duty;
            rep.right_dir  = row.right_dir;
            rep.right_duty = row.right_duty;
        end
        words[0] = '0;
        words[1] = enc_left;
        words[2] = enc_right;
        words[3] = sp_left;
        words[4] = sp_right;
        words[5] = '0;
        count = (row.req.req_type == REQ_STATUS) ? STATUS_WORDS : 1;
        for (int k = 0; k < count; k++)
        begin
            rep.status_index = (count == 1) ? 3'd0 : 3'(k);
            rep.status_word  = (count == 1) ? '0 : words[k];
            rep.last         = (k == count - 1);
            expected_reports.push_back(rep);
        end
    endtask

    task automatic send_item(input script_row_t row);
        while (!sender_calm && $urandom_range(99) < 22)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= row.req.req_type;
        req_bus.command     <= row.req.command;
        req_bus.left_value  <= row.req.left_value;
        req_bus.right_value <= row.req.right_value;
        req_bus.left_step   <= row.req.left_step;
        req_bus.right_step  <= row.req.right_step;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        apply_request(row);
    endtask

    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [7:0] cmd,
                           input int lv, input int rv,
                           input int ls, input int rs,
                           input int fixed, input dir_t ld, input int ldu,
                           input dir_t rd, input int rdu);
        script_row_t row;
        row.req.req_type    = kind;
        row.req.command     = cmd;
        row.req.left_value  = WORD_W'(lv);
        row.req.right_value = WORD_W'(rv);
        row.req.left_step   = STEP_W'(ls);
        row.req.right_step  = STEP_W'(rs);
        row.fixed           = (fixed != 0);
        row.left_dir        = ld;
        row.left_duty       = DUTY_W'(ldu);
        row.right_dir       = rd;
        row.right_duty      = DUTY_W'(rdu);
        script.push_back(row);
    endtask

    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= sink_calm || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        bridge_report_t got;
        bridge_report_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.left_dir     = dir_t'(rsp_bus.left_dir);
            got.left_duty    = rsp_bus.left_duty;
            got.right_dir    = dir_t'(rsp_bus.right_dir);
            got.right_duty   = rsp_bus.right_duty;
            got.status_index = rsp_bus.status_index;
            got.status_word  = rsp_bus.status_word;
            got.last         = rsp_bus.last;
            if (expected_reports.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                begin
                    $display("%0t: result word with nothing pending", $realtime);
                end
                fault_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.left_dir !== want.left_dir || got.left_duty !== want.left_duty ||
                    got.right_dir !== want.right_dir || got.right_duty !== want.right_duty ||
                    got.status_index !== want.status_index ||
                    got.status_word !== want.status_word || got.last !== want.last)
                begin
                    if (fault_count < REPORT_LIMIT)
                    begin
                        $display({"%0t: mismatch expected dir %0d/%0d duty %0d/%0d idx %0d ",
                                  "word %h last %0d, got dir %0d/%0d duty %0d/%0d idx %0d ",
                                  "word %h last %0d"}, $realtime,
                                 want.left_dir, want.right_dir, want.left_duty,
                                 want.right_duty, want.status_index, want.status_word,
                                 want.last, got.left_dir, got.right_dir, got.left_duty,
                                 got.right_duty, got.status_index, got.status_word,
                                 got.last);
                    end
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        script_row_t       row;
        logic [DUTY_W-1:0] limit_value;
        int                pick;

        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= '0;
        req_bus.command     <= '0;
        req_bus.left_value  <= '0;
        req_bus.right_value <= '0;
        req_bus.left_step   <= '0;
        req_bus.right_step  <= '0;
        duty_limit = PWM_MAX_RESET;
        sp_left    = '0;
        sp_right   = '0;
        enc_left   = '0;
        enc_right  = '0;

        add_row(REQ_STATUS, CMD_UNKNOWN_LOW, 0, 0, 0, 0, 1, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_COMMAND, CMD_LOAD_A, 500, -500, 0, 0,
                1, DIR_FORWARD, 500, DIR_BACKWARD, 500);
        add_row(REQ_COMMAND, CMD_LOAD_B, 16'h7FFF, 16'h8000, 0, 0,
                1, DIR_FORWARD, 999, DIR_BACKWARD, 999);
        add_row(REQ_COMMAND, CMD_LOAD_C, -1, 999, 0, 0, 1, DIR_BACKWARD, 1, DIR_FORWARD, 999);
        add_row(REQ_COMMAND, CMD_LOAD_C, 0, 1000, 0, 0, 1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_STEP, CMD_UNKNOWN_HIGH, 16'h8000, 16'h7FFF, 2'b11, 2'b01,
                0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STEP, CMD_UNKNOWN_LOW, 0, 0, 2'b10, 2'b10, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STEP, CMD_UNKNOWN_LOW, 0, 0, 2'b01, 2'b11, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STEP, CMD_UNKNOWN_LOW, 0, 0, 2'b00, 2'b00, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STATUS, CMD_UNKNOWN_HIGH, -1, -1, 2'b11, 2'b11,
                0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_COMMAND, CMD_CLEAR_COUNTS, 1234, -1234, 0, 0,
                1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_STATUS, CMD_UNKNOWN_LOW, 0, 0, 0, 0, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_COMMAND, CMD_UNKNOWN_LOW, 100, 100, 0, 0,
                1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_COMMAND, CMD_UNKNOWN_MID, 100, 100, 0, 0,
                1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_COMMAND, CMD_UNKNOWN_HIGH, 100, 100, 0, 0,
                1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_UNUSED, CMD_UNKNOWN_HIGH, -1, -1, 2'b11, 2'b11,
                1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_UNUSED, CMD_LOAD_A, 0, 0, 0, 0, 1, DIR_STOP, 0, DIR_FORWARD, 999);
        add_row(REQ_COMMAND, CMD_LOAD_A, 16'h8001, 1, 0, 0,
                1, DIR_BACKWARD, 999, DIR_FORWARD, 1);
        add_row(REQ_STEP, CMD_UNKNOWN_LOW, 0, 0, 2'b11, 2'b11, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STATUS, CMD_UNKNOWN_LOW, 0, 0, 0, 0, 0, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_COMMAND, CMD_LOAD_B, 0, 0, 0, 0, 1, DIR_STOP, 0, DIR_STOP, 0);
        add_row(REQ_STATUS, CMD_UNKNOWN_LOW, 0, 0, 0, 0, 1, DIR_STOP, 0, DIR_STOP, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            send_item(script[i]);
        end
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: limit_value = '0;
                1: limit_value = 15'h7FFF;
                2: limit_value = 15'($urandom_range(32767));
                default: limit_value = 15'd1;
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= limit_value;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            duty_limit = limit_value;
            sink_calm   = (phase == 1);
            sender_calm = (phase == 1) || (phase == 2);
            if (phase == 2)
            begin
                hold_req = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                row.fixed           = 1'b0;
                row.left_dir        = DIR_STOP;
                row.left_duty       = '0;
                row.right_dir       = DIR_STOP;
                row.right_duty      = '0;
                row.req.command     = 8'($urandom);
                row.req.left_value  = random_word();
                row.req.right_value = random_word();
                row.req.left_step   = 2'($urandom);
                row.req.right_step  = 2'($urandom);
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    row.req.req_type = REQ_COMMAND;
                    case ($urandom_range(2))
                        0: row.req.command = CMD_LOAD_A;
                        1: row.req.command = CMD_LOAD_B;
                        default: row.req.command = CMD_LOAD_C;
                    endcase
                end
                else if (pick < 38)
                begin
                    row.req.req_type = REQ_COMMAND;
                    row.req.command  = CMD_CLEAR_COUNTS;
                end
                else if (pick < 45)
                begin
                    row.req.req_type = REQ_COMMAND;
                end
                else if (pick < 62)
                begin
                    row.req.req_type = REQ_STATUS;
                end
                else if (pick < 95)
                begin
                    row.req.req_type = REQ_STEP;
                end
                else
                begin
                    row.req.req_type = REQ_UNUSED;
                end
                send_item(row);
            end
            wait_idle();
        end

        sink_calm   = 1'b0;
        sender_calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $display("%0d expected result words never arrived", expected_reports.size());
            fault_count++;
        end
        if (fault_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
